// ----- sv/midirs_pkg.sv -----
// types, codes and the status length decode for the midi running status parser
// depends on nothing; imported by midirs_decode and midi_running_status_parser
package midirs_pkg;

  // kind of input transaction
  typedef enum logic {
    OP_BYTE  = 1'b0,
    OP_CLEAR = 1'b1
  } midirs_op_e;

  localparam logic [7:0] PAD_EMPTY      = 8'hFD;
  localparam logic [7:0] PAD_END        = 8'hFF;
  localparam logic [7:0] REALTIME_BASE  = 8'hF8;
  localparam logic [7:0] SYSCOMMON_BASE = 8'hF0;
  localparam logic [7:0] SC_MTC         = 8'hF1;
  localparam logic [7:0] SC_SONGPOS     = 8'hF2;
  localparam logic [7:0] SC_SONGSEL     = 8'hF3;
  localparam logic [3:0] CV_PROGRAM     = 4'hC;
  localparam logic [3:0] CV_PRESSURE    = 4'hD;

  localparam logic [1:0] LEN_ONE   = 2'd1;
  localparam logic [1:0] LEN_TWO   = 2'd2;
  localparam logic [1:0] LEN_THREE = 2'd3;

  // parser state; data_count only ever counts the one held byte
  typedef struct packed {
    logic [7:0] running_status;
    logic [6:0] held_data;
    logic       data_count;
    logic [1:0] bytes_needed;
  } midirs_state_t;

  // result event, status byte in the lowest bits
  typedef struct packed {
    logic [1:0] event_length;
    logic [6:0] second_data;
    logic [6:0] first_data;
    logic [7:0] status_byte;
  } midirs_event_t;

  // data bytes that follow a status byte
  function automatic logic [1:0] data_len_of(input logic [7:0] s);
    logic [1:0] n;
    if (s >= REALTIME_BASE) begin
      n = 2'd0;
    end else if (s >= SYSCOMMON_BASE) begin
      if (s == SC_MTC || s == SC_SONGSEL) n = 2'd1;
      else if (s == SC_SONGPOS) n = 2'd2;
      else n = 2'd0;
    end else if (s[7:4] == CV_PROGRAM || s[7:4] == CV_PRESSURE) begin
      n = 2'd1;
    end else begin
      n = 2'd2;
    end
    return n;
  endfunction

endpackage

// ----- sv/midi_running_status_parser.sv -----
// top level of the midi running status parser: input register, decode, result register
// depends on midirs_pkg and midirs_decode
//
//  channel  | direction | tdata                                   | tuser
//  s_axis   | in        | [7:0] byte_value                        | [0] op
//  m_axis   | out       | [7:0] status_byte [14:8] first_data     | -
//           |           | [21:15] second_data [23:22] event_length|
//
// one byte per cycle sustained while m_axis does not stall; an accepted transaction lands
// in the input register first and is then registered into the result register
// the decode between them is a few compares on the byte and the parser state
// rst_ni clears the parser state and both valid flags; payload registers keep junk
// a stall on m_axis holds the result and lets one more byte sit in the input register
// bytes that give no event (padding, data of a partial event, clear) retire
// without using an output slot
module midi_running_status_parser
  import midirs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic        s_axis_tuser,   // [0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // status_byte, first_data, second_data, event_length
);

  // input register
  logic          in_vld_q;
  midirs_op_e    in_op_q;
  logic [7:0]    in_byte_q;

  // parser state and result register
  midirs_state_t state_q, state_d;
  logic          out_vld_q;
  midirs_event_t out_q, event_d;
  logic          emit_d;

  logic          advance;

  // result slot free or being drained this cycle
  assign advance       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || advance;

  midirs_decode u_decode (
    .op_i    (in_op_q),
    .byte_i  (in_byte_q),
    .state_i (state_q),
    .state_o (state_d),
    .emit_o  (emit_d),
    .event_o (event_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q   <= midirs_op_e'(s_axis_tuser);
      in_byte_q <= s_axis_tdata;
    end
  end

  // state moves only when the held byte is decoded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= '0;
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q && emit_d;
      if (in_vld_q) state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_vld_q && emit_d) out_q <= event_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // running status only ever holds a status byte
  a_status_msb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.running_status != '0 |-> state_q.running_status[7])
    else $error("running status without status bit");

  // a held data byte only exists for a three byte event
  a_held_three: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.data_count |-> state_q.bytes_needed == 2'd2 && state_q.running_status != '0)
    else $error("held data byte without a pending three byte event");

  // every emitted event is well formed
  a_event_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_q.status_byte[7] && out_q.event_length != 2'd0)
    else $error("malformed event in result register");

  // a clear decoded leaves no active status and no event
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_vld_q && in_op_q == OP_CLEAR |=>
      state_q.running_status == '0 && !out_vld_q)
    else $error("clear did not reset the parser");

endmodule

// ----- sv/midirs_decode.sv -----
// combinational byte decode: next parser state and the event it completes
// depends on midirs_pkg
module midirs_decode
  import midirs_pkg::*;
(
  input  midirs_op_e    op_i,
  input  logic [7:0]    byte_i,
  input  midirs_state_t state_i,
  output midirs_state_t state_o,
  output logic          emit_o,
  output midirs_event_t event_o
);

  always_comb begin
    state_o = state_i;
    emit_o  = 1'b0;
    event_o = '0;

    if (op_i == OP_CLEAR) begin
      state_o.running_status = '0;
      state_o.data_count     = 1'b0;
      state_o.bytes_needed   = '0;
    end else if (byte_i == PAD_EMPTY || byte_i == PAD_END) begin
      // padding, dropped
    end else if (byte_i >= REALTIME_BASE) begin
      emit_o               = 1'b1;
      event_o.status_byte  = byte_i;
      event_o.event_length = LEN_ONE;
    end else if (byte_i[7]) begin
      state_o.running_status = byte_i;
      state_o.data_count     = 1'b0;
      state_o.bytes_needed   = data_len_of(byte_i);
      if (data_len_of(byte_i) == 2'd0) begin
        emit_o               = 1'b1;
        event_o.status_byte  = byte_i;
        event_o.event_length = LEN_ONE;
        if (byte_i >= SYSCOMMON_BASE) state_o.running_status = '0;
      end
    end else if (state_i.running_status != '0) begin
      event_o.status_byte = state_i.running_status;
      if (state_i.bytes_needed == 2'd0) begin
        emit_o               = 1'b1;
        event_o.event_length = LEN_ONE;
      end else if (state_i.bytes_needed == 2'd1) begin
        emit_o               = 1'b1;
        event_o.first_data   = byte_i[6:0];
        event_o.event_length = LEN_TWO;
      end else if (!state_i.data_count) begin
        state_o.held_data  = byte_i[6:0];
        state_o.data_count = 1'b1;
      end else begin
        emit_o               = 1'b1;
        event_o.first_data   = state_i.held_data;
        event_o.second_data  = byte_i[6:0];
        event_o.event_length = LEN_THREE;
      end
      if (emit_o) begin
        state_o.data_count = 1'b0;
        if (state_i.running_status >= SYSCOMMON_BASE) state_o.running_status = '0;
      end
    end
  end

endmodule
